[hdl/smcrc_pkg.sv]
// ----------------------------------------------------------------------------
// Soil moisture conditioner package
// Shared word types, command and result codes, and fixed field widths.
// ----------------------------------------------------------------------------
package smcrc_pkg;

   localparam int CMD_W    = 2;
   localparam int CHAN_W   = 2;
   localparam int ADC_W    = 12;   // width of the sample field
   localparam int CAL_W    = 12;   // width of a calibration point
   localparam int RAW_W    = 12;
   localparam int PCT_W    = 7;
   localparam int MASK_W   = 4;
   localparam int THRESH_W = 8;
   localparam int NUM_W    = 19;   // |raw - dry| * 100 fits here

   localparam logic [CMD_W-1:0] CMD_SAMPLE    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SNAPSHOT  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CHECK     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_CALIBRATE = 2'd3;

   localparam logic KIND_READING = 1'b0;
   localparam logic KIND_RISE    = 1'b1;

   localparam logic [CAL_W-1:0]           DRY_RESET    = 12'd1700;
   localparam logic [CAL_W-1:0]           WET_RESET    = 12'd700;
   localparam logic signed [THRESH_W-1:0] THRESH_RESET = 8'sd5;
   localparam logic [PCT_W-1:0]           PCT_MAX      = 7'd100;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [CHAN_W-1:0] channel;
      logic [ADC_W-1:0]  sample;
      logic [CAL_W-1:0]  air_value;
      logic [CAL_W-1:0]  water_value;
   } req_type;

   typedef struct packed {
      logic              kind;
      logic [CHAN_W-1:0] out_channel;
      logic [RAW_W-1:0]  raw_value;
      logic [PCT_W-1:0]  percent;
      logic              cal_error;
      logic [MASK_W-1:0] rise_mask;
      logic              tank_empty;
   } rsp_type;

   // Handshake between the front queue and the back sequencer
   typedef struct packed {
      logic    valid;
      req_type data;
   } queue_word_type;

endpackage

[hdl/smcrc_front.sv]
// ----------------------------------------------------------------------------
// Soil moisture conditioner front end
// Accepts command words and queues all but absent-channel sample/calibrate.
// ----------------------------------------------------------------------------
module smcrc_front
   import smcrc_pkg::*;
#(
   parameter int NUM_CHANNELS = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  req_type        req_data,
   output queue_word_type q_word,
   input  logic           q_pop
);

   localparam int DEPTH = 2;

   req_type    entry_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;
   logic       drop;
   logic       push;
   logic       pop;

   // Sample and calibrate words for an absent channel have no effect at all
   assign drop = ((req_data.cmd == CMD_SAMPLE) || (req_data.cmd == CMD_CALIBRATE)) &&
                 (32'(req_data.channel) >= NUM_CHANNELS);

   assign req_ready = (count_ff != 2'(DEPTH));
   assign accept    = req_valid && req_ready;
   assign push      = accept && !drop;
   assign pop       = q_pop && (count_ff != 2'd0);

   assign q_word.valid = (count_ff != 2'd0);
   assign q_word.data  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= req_data;
      end
   end

endmodule

[hdl/smcrc_div.sv]
// ----------------------------------------------------------------------------
// Soil moisture conditioner serial divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module smcrc_div
   import smcrc_pkg::*;
#(
   parameter int DIVIDEND_W = 19,
   parameter int DIVISOR_W  = 12
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  div_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic                  busy_ff;
   logic                  done_ff;
   logic [DIVISOR_W:0]    trial;
   logic [DIVISOR_W:0]    trial_sub;
   logic                  fits;

   assign trial     = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign fits      = (trial >= {1'b0, div_ff});

   always_comb begin
      rem_in  = fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quot_in = {quot_ff[DIVIDEND_W-2:0], fits};
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DIVIDEND_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         quot_ff <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
      end
   end

endmodule

[hdl/smcrc_back.sv]
// ----------------------------------------------------------------------------
// Soil moisture conditioner back end
// Executes queued commands: accumulation, calibration mapping, snapshot, rise check.
// ----------------------------------------------------------------------------
module smcrc_back
   import smcrc_pkg::*;
#(
   parameter int NUM_CHANNELS        = 4,
   parameter int SAMPLES_PER_READING = 5,
   parameter int ADC_BITS            = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  queue_word_type      q_word,
   output logic                q_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [THRESH_W-1:0] csr_wdata
);

   localparam int SAMPLE_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;
   localparam int CNT_W    = $clog2(SAMPLES_PER_READING + 1);
   localparam int SUM_W    = SAMPLE_W + CNT_W;
   localparam int IDX_W    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ROSE_W   = (NUM_CHANNELS > MASK_W) ? NUM_CHANNELS : MASK_W;

   // Mean by reciprocal multiply; the shift is wide enough that the floor is
   // exact for every sum the accumulator can reach.
   localparam int MEAN_SH     = SUM_W + CNT_W;
   localparam int RECIP_W     = MEAN_SH + 1;
   localparam int MEAN_PROD_W = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'((2**MEAN_SH + SAMPLES_PER_READING - 1) / SAMPLES_PER_READING);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_SCALE,
      ST_DIV_PCT,
      ST_EMIT
   } state_type;

   state_type                   state_ff, state_in;
   rsp_type                     res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_type                     rsp_data_ff, rsp_data_in;
   logic signed [THRESH_W-1:0]  thr_ff;
   logic [SUM_W-1:0]            mean_sum_ff, mean_sum_in;
   logic [CAL_W-1:0]            dry_ff  [NUM_CHANNELS];
   logic [CAL_W-1:0]            dry_in  [NUM_CHANNELS];
   logic [CAL_W-1:0]            wet_ff  [NUM_CHANNELS];
   logic [CAL_W-1:0]            wet_in  [NUM_CHANNELS];
   logic [SUM_W-1:0]            sum_ff  [NUM_CHANNELS];
   logic [SUM_W-1:0]            sum_in  [NUM_CHANNELS];
   logic [CNT_W-1:0]            cnt_ff  [NUM_CHANNELS];
   logic [CNT_W-1:0]            cnt_in  [NUM_CHANNELS];
   logic [PCT_W-1:0]            cur_ff  [NUM_CHANNELS];
   logic [PCT_W-1:0]            cur_in  [NUM_CHANNELS];
   logic [PCT_W-1:0]            snap_ff [NUM_CHANNELS];
   logic [PCT_W-1:0]            snap_in [NUM_CHANNELS];

   logic [IDX_W-1:0]            q_idx;
   logic [IDX_W-1:0]            r_idx;
   logic [SUM_W-1:0]            acc;
   logic [CNT_W-1:0]            cnt_next;
   logic [MEAN_PROD_W-1:0]      mean_prod;
   logic [RAW_W-1:0]            mean_raw;
   logic [ROSE_W-1:0]           rose;
   logic signed [CAL_W:0]       diff;
   logic signed [CAL_W:0]       span;
   logic [CAL_W:0]              diff_neg;
   logic [CAL_W:0]              span_neg;
   logic [CAL_W-1:0]            diff_mag;
   logic [CAL_W-1:0]            span_mag;
   logic [NUM_W-1:0]            prod;
   logic                        in_range;
   logic                        div_start;
   logic [NUM_W-1:0]            div_dividend;
   logic [CAL_W-1:0]            div_divisor;
   logic                        div_done;
   logic [NUM_W-1:0]            div_quot;

   smcrc_div #(
      .DIVIDEND_W (NUM_W),
      .DIVISOR_W  (CAL_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign q_idx    = IDX_W'(q_word.data.channel);
   assign r_idx    = IDX_W'(res_ff.out_channel);
   assign acc      = sum_ff[q_idx] + SUM_W'(q_word.data.sample[SAMPLE_W-1:0]);
   assign cnt_next = cnt_ff[q_idx] + 1'b1;

   assign mean_prod = MEAN_PROD_W'(mean_sum_ff) * MEAN_PROD_W'(MEAN_RECIP);
   assign mean_raw  = RAW_W'(mean_prod >> MEAN_SH);

   // Mapping operands: sign of (raw - dry) against sign of (wet - dry)
   assign diff     = $signed({1'b0, res_ff.raw_value}) - $signed({1'b0, dry_ff[r_idx]});
   assign span     = $signed({1'b0, wet_ff[r_idx]}) - $signed({1'b0, dry_ff[r_idx]});
   assign diff_neg = -diff;
   assign span_neg = -span;
   assign diff_mag = diff[CAL_W] ? diff_neg[CAL_W-1:0] : diff[CAL_W-1:0];
   assign span_mag = span[CAL_W] ? span_neg[CAL_W-1:0] : span[CAL_W-1:0];
   assign prod     = NUM_W'(diff_mag) * NUM_W'(PCT_MAX);
   // Quotient is positive only for a nonzero numerator of the same sign
   assign in_range = (diff != '0) && (diff[CAL_W] == span[CAL_W]);

   // Rise check, one comparator per channel
   always_comb begin
      logic signed [THRESH_W-1:0] delta;
      rose = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         delta = $signed({1'b0, cur_ff[i]}) - $signed({1'b0, snap_ff[i]});
         rose[i] = (delta >= thr_ff);
      end
   end

   always_comb begin
      state_in     = state_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mean_sum_in  = mean_sum_ff;
      dry_in       = dry_ff;
      wet_in       = wet_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      cur_in       = cur_ff;
      snap_in      = snap_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div_dividend = '0;
      div_divisor  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_word.valid) begin
               q_pop = 1'b1;
               unique case (q_word.data.cmd)
                  CMD_SAMPLE: begin
                     if (cnt_next < CNT_W'(SAMPLES_PER_READING)) begin
                        sum_in[q_idx] = acc;
                        cnt_in[q_idx] = cnt_next;
                     end else begin
                        // Last sample: clear accumulator, hold the sum for the mean
                        sum_in[q_idx]      = '0;
                        cnt_in[q_idx]      = '0;
                        res_in             = '0;
                        res_in.kind        = KIND_READING;
                        res_in.out_channel = q_word.data.channel;
                        mean_sum_in        = acc;
                        state_in           = ST_MEAN;
                     end
                  end
                  CMD_SNAPSHOT: begin
                     snap_in = cur_ff;
                  end
                  CMD_CHECK: begin
                     res_in            = '0;
                     res_in.kind       = KIND_RISE;
                     res_in.rise_mask  = rose[MASK_W-1:0];
                     res_in.tank_empty = ~|rose;
                     state_in          = ST_EMIT;
                  end
                  CMD_CALIBRATE: begin
                     dry_in[q_idx] = q_word.data.air_value;
                     wet_in[q_idx] = q_word.data.water_value;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MEAN: begin
            res_in.raw_value = mean_raw;
            if (dry_ff[r_idx] == wet_ff[r_idx]) begin
               res_in.percent   = '0;
               res_in.cal_error = 1'b1;
               state_in         = ST_EMIT;
            end else begin
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (in_range) begin
               div_start    = 1'b1;
               div_dividend = prod;
               div_divisor  = span_mag;
               state_in     = ST_DIV_PCT;
            end else begin
               res_in.percent = '0;
               state_in       = ST_EMIT;
            end
         end
         ST_DIV_PCT: begin
            if (div_done) begin
               res_in.percent = (div_quot > NUM_W'(PCT_MAX)) ? PCT_MAX
                                                            : div_quot[PCT_W-1:0];
               state_in       = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               if (res_ff.kind == KIND_READING) begin
                  cur_in[r_idx] = res_ff.percent;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THRESH_RESET;
         for (int i = 0; i < NUM_CHANNELS; i++) begin
            dry_ff[i]  <= DRY_RESET;
            wet_ff[i]  <= WET_RESET;
            sum_ff[i]  <= '0;
            cnt_ff[i]  <= '0;
            cur_ff[i]  <= '0;
            snap_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            thr_ff <= $signed(csr_wdata);
         end
         dry_ff  <= dry_in;
         wet_ff  <= wet_in;
         sum_ff  <= sum_in;
         cnt_ff  <= cnt_in;
         cur_ff  <= cur_in;
         snap_ff <= snap_in;
      end
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      mean_sum_ff <= mean_sum_in;
   end

endmodule

[hdl/soil_moisture_calibrate_and_rise_check.sv]
// ----------------------------------------------------------------------------
// Soil moisture calibrate and rise check
// Multi-channel moisture conditioner with two-point calibration and rise test.
// ----------------------------------------------------------------------------
// Each request word carries one command. A sample word adds one ADC reading
// to its channel's accumulator; the last sample of a reading produces one
// reading word with the truncated mean and the calibrated percent (dry point
// maps to 0, wet point to 100, truncated toward zero, clamped to 0..100, and
// percent 0 with cal_error set when the two points are equal). A snapshot word
// copies all current percents; a check word returns one rise word whose mask
// has a bit per channel that rose by at least the threshold register, with
// tank_empty set when none did. Calibrate words load a channel's dry/wet pair.
// Sample and calibrate words for a channel at or above NUM_CHANNELS are
// dropped. Request words enter a two-word queue, so the port takes up to two
// more words while a result waits on the response side. The back end runs one
// word at a time. For a reading, the mean comes from a registered reciprocal
// multiply, and the percent from one pass through the 19-bit serial divider at
// one quotient bit per cycle. A reading with an equal pair, or one at the dry
// point or on its dry side, skips the divider. There is no clearing pass after
// reset.
// ----------------------------------------------------------------------------
module soil_moisture_calibrate_and_rise_check
   import smcrc_pkg::*;
#(
   parameter int NUM_CHANNELS        = 4,
   parameter int SAMPLES_PER_READING = 5,
   parameter int ADC_BITS            = 12
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  req_type             req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rsp_type             rsp_data,
   input  logic                csr_we,
   input  logic [THRESH_W-1:0] csr_wdata
);

   queue_word_type q_word;
   logic           q_pop;

   // Front: accept, queue all but absent-channel sample/calibrate words
   smcrc_front #(
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .q_word    (q_word),
      .q_pop     (q_pop)
   );

   // Back: per-channel state, divider sequencing and the result register
   smcrc_back #(
      .NUM_CHANNELS        (NUM_CHANNELS),
      .SAMPLES_PER_READING (SAMPLES_PER_READING),
      .ADC_BITS            (ADC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_word    (q_word),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

endmodule

[tb/soil_moisture_calibrate_and_rise_check_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Soil moisture calibrate and rise check testbench
// Drives command words with random pacing and checks every result word
// against a cycle-free predictor of the conditioner. The run opens with a
// short table of hand-picked words and ends with phases of random traffic,
// each under a newly set rise threshold.
// ----------------------------------------------------------------------------
module soil_moisture_calibrate_and_rise_check_tb;
   import smcrc_pkg::*;

   localparam int NUM_CH       = 4;
   localparam int SAMPLES      = 5;
   localparam int SETTLE       = 64;      // settle time for words that give no result
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int PHASE_WORDS  = 57;
   localparam int NUM_PHASES   = 7;
   localparam int REQ_W        = $bits(req_type);

   // One row of the hand-picked stimulus; fixed rows carry their result.
   typedef struct {
      req_type word;
      bit      fixed;
      rsp_type rsp;
   } plan_row_type;

   logic                clock;
   logic                reset     = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   req_type             req_data  = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we    = 1'b0;
   logic [THRESH_W-1:0] csr_wdata = '0;

   // Predictor state: one copy of every per-channel register of the block.
   int                  dry_pt   [NUM_CH];
   int                  wet_pt   [NUM_CH];
   int                  acc_sum  [NUM_CH];
   int                  acc_cnt  [NUM_CH];
   int                  pct_now  [NUM_CH];
   int                  pct_snap [NUM_CH];
   logic signed [7:0]   rise_thresh;

   rsp_type             owed_results[$];   // result words still to come, oldest first
   plan_row_type        plan[$];
   bit                  failed    = 1'b0;
   bit                  calm      = 1'b0;  // no idling on either side while set
   int                  hold_left = 0;
   int                  cycle_count = 0;

   soil_moisture_calibrate_and_rise_check u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: stop a hung run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("** soil_moisture_calibrate_and_rise_check: FAILED **");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Predictor: apply one accepted word to the model state and report the
   // result word it causes, if any.
   // ------------------------------------------------------------------------
   function automatic bit condition_word(input req_type w, output rsp_type r);
      int ch;
      int raw;
      int num;
      int den;
      int pct;
      logic [MASK_W-1:0] mask;
      r    = '0;
      ch   = w.channel;
      mask = '0;
      case (w.cmd)
         CMD_SAMPLE: begin
            // Accumulate; only the last sample of a reading gives a word.
            acc_sum[ch] += int'(w.sample);
            acc_cnt[ch]++;
            if (acc_cnt[ch] < SAMPLES) return 1'b0;
            raw = acc_sum[ch] / SAMPLES;
            acc_sum[ch] = 0;
            acc_cnt[ch] = 0;
            if (dry_pt[ch] == wet_pt[ch]) begin
               // Equal calibration pair: force percent to zero and flag it.
               pct = 0;
               r.cal_error = 1'b1;
            end else begin
               // Signed int division truncates toward zero, then clamp.
               num = (raw - dry_pt[ch]) * 100;
               den = wet_pt[ch] - dry_pt[ch];
               pct = num / den;
               if (pct < 0) pct = 0;
               if (pct > int'(PCT_MAX)) pct = int'(PCT_MAX);
            end
            pct_now[ch]   = pct;
            r.kind        = KIND_READING;
            r.out_channel = w.channel;
            r.raw_value   = raw[RAW_W-1:0];
            r.percent     = pct[PCT_W-1:0];
            return 1'b1;
         end
         CMD_SNAPSHOT: begin
            pct_snap = pct_now;
            return 1'b0;
         end
         CMD_CHECK: begin
            for (int i = 0; i < NUM_CH; i++)
               if (pct_now[i] - pct_snap[i] >= int'(rise_thresh)) mask[i] = 1'b1;
            r.kind       = KIND_RISE;
            r.rise_mask  = mask;
            r.tank_empty = (mask == '0);
            return 1'b1;
         end
         default: begin
            // Calibrate: load the dry/wet pair of the channel.
            dry_pt[ch] = int'(w.air_value);
            wet_pt[ch] = int'(w.water_value);
            return 1'b0;
         end
      endcase
   endfunction

   function automatic plan_row_type entry(input logic [CMD_W-1:0] cmd,
                                          input logic [CHAN_W-1:0] ch,
                                          input logic [ADC_W-1:0] smp,
                                          input logic [CAL_W-1:0] air,
                                          input logic [CAL_W-1:0] wat,
                                          input bit fixed, input rsp_type rsp);
      plan_row_type p;
      p.word.cmd         = cmd;
      p.word.channel     = ch;
      p.word.sample      = smp;
      p.word.air_value   = air;
      p.word.water_value = wat;
      p.fixed            = fixed;
      p.rsp              = rsp;
      return p;
   endfunction

   // Append one row to the stimulus table.
   function automatic void add_row(input plan_row_type row);
      plan.insert(plan.size(), row);
   endfunction

   function automatic rsp_type reading(input logic [CHAN_W-1:0] ch,
                                       input logic [RAW_W-1:0] raw,
                                       input logic [PCT_W-1:0] pct, input logic err);
      rsp_type r;
      r             = '0;
      r.kind        = KIND_READING;
      r.out_channel = ch;
      r.raw_value   = raw;
      r.percent     = pct;
      r.cal_error   = err;
      return r;
   endfunction

   function automatic rsp_type rise(input logic [MASK_W-1:0] mask, input logic empty);
      rsp_type r;
      r            = '0;
      r.kind       = KIND_RISE;
      r.rise_mask  = mask;
      r.tank_empty = empty;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Request side: idle for a random gap, present the word, hold it until
   // accepted, then record what it should produce. Valid is left high after
   // acceptance so a back-to-back word takes a single assignment.
   // ------------------------------------------------------------------------
   task automatic send_word(input req_type w, input bit use_fixed, input rsp_type fixed_rsp);
      int      gap;
      rsp_type r;
      gap = calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (condition_word(w, r))
         owed_results.insert(owed_results.size(), use_fixed ? fixed_rsp : r);
   endtask

   // Drop valid, wait for every owed word, then let words that give no
   // result finish inside the block.
   task automatic drain();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_threshold(input logic signed [7:0] value);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      rise_thresh = value;
      csr_we    <= 1'b0;
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         failed = 1'b1;
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: check each accepted word against the oldest expectation,
   // then stall for a random number of cycles before taking the next one.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               $display("%0t: unexpected result word, expected none, got %h",
                        $time, rsp_data);
               failed = 1'b1;
            end else begin
               want = owed_results.pop_front();
               check_field("kind",        want.kind,        rsp_data.kind);
               check_field("out_channel", want.out_channel, rsp_data.out_channel);
               check_field("raw_value",   want.raw_value,   rsp_data.raw_value);
               check_field("percent",     want.percent,     rsp_data.percent);
               check_field("cal_error",   want.cal_error,   rsp_data.cal_error);
               check_field("rise_mask",   want.rise_mask,   rsp_data.rise_mask);
               check_field("tank_empty",  want.tank_empty,  rsp_data.tank_empty);
            end
            hold_left = calm ? 0 : $urandom_range(0, 4);
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_type           w;
      int                lo;
      int                hi;
      int                ch;
      logic signed [7:0] step_thresh;

      // Hold the predictor at its reset state.
      rise_thresh = THRESH_RESET;
      for (int i = 0; i < NUM_CH; i++) begin
         dry_pt[i]   = int'(DRY_RESET);
         wet_pt[i]   = int'(WET_RESET);
         acc_sum[i]  = 0;
         acc_cnt[i]  = 0;
         pct_now[i]  = 0;
         pct_snap[i] = 0;
      end

      // Hand-picked words, all under the reset threshold of 5.
      // Nothing has risen right after reset: empty mask, tank empty.
      add_row(entry(CMD_CHECK, 2'd0, 12'd0, 12'd0, 12'd0, 1'b1, rise(4'b0000, 1'b1)));
      add_row(entry(CMD_SNAPSHOT, 2'd0, 12'd0, 12'd0, 12'd0, 1'b0, '0));
      // Full-scale samples on channel 0: far past the dry point, clamps to 0.
      for (int i = 0; i < SAMPLES - 1; i++)
         add_row(entry(CMD_SAMPLE, 2'd0, 12'd4095, 12'd0, 12'd0, 1'b0, '0));
      add_row(entry(CMD_SAMPLE, 2'd0, 12'd4095, 12'd0, 12'd0, 1'b1,
                    reading(2'd0, 12'd4095, 7'd0, 1'b0)));
      // Zero samples on channel 1: past the wet point, clamps to 100.
      for (int i = 0; i < SAMPLES - 1; i++)
         add_row(entry(CMD_SAMPLE, 2'd1, 12'd0, 12'd0, 12'd0, 1'b0, '0));
      add_row(entry(CMD_SAMPLE, 2'd1, 12'd0, 12'd0, 12'd0, 1'b1,
                    reading(2'd1, 12'd0, 7'd100, 1'b0)));
      // Equal calibration pair on channel 2: percent 0 with the error flag.
      add_row(entry(CMD_CALIBRATE, 2'd2, 12'd0, 12'd4095, 12'd4095, 1'b0, '0));
      for (int i = 0; i < SAMPLES - 1; i++)
         add_row(entry(CMD_SAMPLE, 2'd2, 12'd1234, 12'd0, 12'd0, 1'b0, '0));
      add_row(entry(CMD_SAMPLE, 2'd2, 12'd1234, 12'd0, 12'd0, 1'b1,
                    reading(2'd2, 12'd1234, 7'd0, 1'b1)));
      // Only channel 1 rose since the snapshot.
      add_row(entry(CMD_CHECK, 2'd3, 12'd0, 12'd0, 12'd0, 1'b1, rise(4'b0010, 1'b0)));
      // Fresh snapshot: nothing rose again.
      add_row(entry(CMD_SNAPSHOT, 2'd1, 12'd0, 12'd0, 12'd0, 1'b0, '0));
      add_row(entry(CMD_CHECK, 2'd2, 12'd0, 12'd0, 12'd0, 1'b1, rise(4'b0000, 1'b1)));
      // Calibration extremes, then restore channel 2 to the reset pair.
      add_row(entry(CMD_CALIBRATE, 2'd3, 12'd0, 12'd0, 12'd4095, 1'b0, '0));
      add_row(entry(CMD_CALIBRATE, 2'd2, 12'd0, DRY_RESET, WET_RESET, 1'b0, '0));

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) send_word(plan[i].word, plan[i].fixed, plan[i].rsp);
      drain();

      // Random phases: threshold extremes and small values first, then a random one.
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0:       step_thresh = -8'sd100;
            1:       step_thresh = 8'sd100;
            2:       step_thresh = 8'sd0;
            3:       step_thresh = -8'sd1;
            4:       step_thresh = 8'sd1;
            5:       step_thresh = 8'sd37;
            default: step_thresh = THRESH_W'($urandom_range(0, 200) - 100);
         endcase
         set_threshold(step_thresh);

         for (int n = 0; n < PHASE_WORDS; n++) begin
            // Toggle runs with no idling now and then.
            if (n % 20 == 0) calm = ($urandom_range(0, 3) == 0);
            w  = req_type'(REQ_W'({$urandom, $urandom}));
            ch = w.channel;
            lo = (dry_pt[ch] < wet_pt[ch]) ? dry_pt[ch] : wet_pt[ch];
            hi = (dry_pt[ch] < wet_pt[ch]) ? wet_pt[ch] : dry_pt[ch];
            lo = (lo < 60) ? 0 : lo - 60;
            hi = (hi > 4035) ? 4095 : hi + 60;
            lo = $urandom_range(0, 99);
            if (lo < 68) begin
               // Mostly land in or near the calibration window so percents spread.
               w.cmd = CMD_SAMPLE;
               lo    = (dry_pt[ch] < wet_pt[ch]) ? dry_pt[ch] : wet_pt[ch];
               lo    = (lo < 60) ? 0 : lo - 60;
               if ($urandom_range(0, 3) != 0) w.sample = ADC_W'($urandom_range(hi, lo));
            end else if (lo < 76) begin
               w.cmd = CMD_SNAPSHOT;
            end else if (lo < 88) begin
               w.cmd = CMD_CHECK;
            end else begin
               w.cmd = CMD_CALIBRATE;
               case ($urandom_range(0, 7))
                  0: w.water_value = w.air_value;
                  1: begin
                     w.air_value   = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
                     w.water_value = ~w.air_value;
                  end
                  2: begin
                     w.air_value   = CAL_W'($urandom_range(4090, 5));
                     w.water_value = CAL_W'(w.air_value + $urandom_range(0, 6) - 3);
                  end
                  3: begin
                     w.air_value   = DRY_RESET;
                     w.water_value = WET_RESET;
                  end
                  default: ;
               endcase
            end
            send_word(w, 1'b0, '0);
         end
         calm = 1'b0;
         drain();
      end

      if (failed) begin
         $display("** soil_moisture_calibrate_and_rise_check: FAILED **");
      end else begin
         $display("** soil_moisture_calibrate_and_rise_check: PASSED **");
      end
      $finish;
   end

endmodule
